FILE: rtl/avr_abe_pkg.sv
// ----------------------------------------------------------------------------
// avr_abe_pkg
// Shared constants and types for the AVR ALU and branch execute block.
// ----------------------------------------------------------------------------
package avr_abe_pkg;

   localparam int PC_WIDTH = 22;
   localparam int PC_PORT_WIDTH = 22;

   localparam logic [4:0] OP_ADC  = 5'd0;
   localparam logic [4:0] OP_ADD  = 5'd1;
   localparam logic [4:0] OP_AND  = 5'd2;
   localparam logic [4:0] OP_ANDI = 5'd3;
   localparam logic [4:0] OP_BCLR = 5'd4;
   localparam logic [4:0] OP_BSET = 5'd5;
   localparam logic [4:0] OP_BLD  = 5'd6;
   localparam logic [4:0] OP_BST  = 5'd7;
   localparam logic [4:0] OP_BRBC = 5'd8;
   localparam logic [4:0] OP_BRBS = 5'd9;
   localparam logic [4:0] OP_JMP  = 5'd10;
   localparam logic [4:0] OP_CBI  = 5'd11;
   localparam logic [4:0] OP_CBR  = 5'd12;
   localparam logic [4:0] OP_CLR  = 5'd13;
   localparam logic [4:0] OP_COM  = 5'd14;
   localparam logic [4:0] OP_CP   = 5'd15;
   localparam logic [4:0] OP_CPC  = 5'd16;
   localparam logic [4:0] OP_CPI  = 5'd17;
   localparam logic [4:0] OP_DEC  = 5'd18;
   localparam logic [4:0] OP_EOR  = 5'd19;
   localparam logic [4:0] OP_INC  = 5'd20;
   localparam logic [4:0] OP_LDI  = 5'd21;
   localparam logic [4:0] OP_LSL  = 5'd22;
   localparam logic [4:0] OP_LSR  = 5'd23;
   localparam logic [4:0] OP_MOV  = 5'd24;
   localparam logic [4:0] OP_NEG  = 5'd25;
   localparam logic [4:0] OP_NOP  = 5'd26;
   localparam logic [4:0] OP_SBR  = 5'd27;
   localparam logic [4:0] OP_SER  = 5'd28;
   localparam logic [4:0] OP_TST  = 5'd29;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_N = 2;
   localparam int FLAG_V = 3;
   localparam int FLAG_S = 4;
   localparam int FLAG_H = 5;
   localparam int FLAG_T = 6;

   typedef struct packed {
      logic [PC_WIDTH-1:0] pc;
      logic [7:0]          value;
      logic                written;
      logic [7:0]          sreg;
      logic                taken;
   } exec_result_type;

endpackage

FILE: rtl/avr_alu_branch_execute.sv
// the request is registered into the execute stage on accept and its result into
// the result register; throughput: one transaction per cycle unless the response
// is stalled; the register file is read on accept and the write of the instruction
// ahead is forwarded into execute; reset: synchronous, pc and status clear, register
// file valid bits clear so registers read zero until written; no clearing pass
// ----------------------------------------------------------------------------
// avr_alu_branch_execute
// Top level: register file memory, operand fetch, execute stage, result register.
// ----------------------------------------------------------------------------
module avr_alu_branch_execute (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [4:0]        req_type,
   input  logic [4:0]        req_dest_reg,
   input  logic [4:0]        req_src_reg,
   input  logic [7:0]        req_immediate,
   input  logic [2:0]        req_bit_sel,
   input  logic signed [6:0] req_branch_offset,
   input  logic [21:0]       req_jump_target,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [avr_abe_pkg::PC_PORT_WIDTH-1:0] rsp_next_pc,
   output logic [7:0]        rsp_dest_value,
   output logic              rsp_dest_written,
   output logic [7:0]        rsp_status_flags,
   output logic              rsp_branch_taken
);
   import avr_abe_pkg::*;

   logic [7:0]  mem [32];
   logic [31:0] valid_ff;

   logic              req_acc;
   logic              s1_adv;
   logic              s1_valid_ff, s1_valid_in;
   logic [4:0]        s1_type_ff;
   logic [4:0]        s1_dest_ff;
   logic [4:0]        s1_src_ff;
   logic [7:0]        s1_imm_ff;
   logic [2:0]        s1_bit_ff;
   logic signed [6:0] s1_off_ff;
   logic [21:0]       s1_tgt_ff;
   logic [7:0]        rd_data_ff, rr_data_ff;
   logic              rd_vld_ff, rr_vld_ff;
   logic              fwd_valid_ff;
   logic [4:0]        fwd_addr_ff;
   logic [7:0]        fwd_data_ff;
   logic [7:0]        rd_op, rr_op;

   logic [PC_WIDTH-1:0] pc_ff;
   logic [7:0]          sreg_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   exec_result_type     rsp_ff;
   exec_result_type     ex_res;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   // the instruction ahead writes at the same edge that this one reads
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_dest_ff) begin
         rd_op = fwd_data_ff;
      end else begin
         rd_op = rd_vld_ff ? rd_data_ff : 8'h00;
      end
      if (fwd_valid_ff && fwd_addr_ff == s1_src_ff) begin
         rr_op = fwd_data_ff;
      end else begin
         rr_op = rr_vld_ff ? rr_data_ff : 8'h00;
      end
   end

   avr_abe_alu u_alu (
      .op      (s1_type_ff),
      .rd      (rd_op),
      .rr      (rr_op),
      .imm     (s1_imm_ff),
      .bit_sel (s1_bit_ff),
      .offset  (s1_off_ff),
      .target  (s1_tgt_ff),
      .sreg    (sreg_ff),
      .pc      (pc_ff),
      .result  (ex_res)
   );

   // register file memory
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_data_ff <= mem[req_dest_reg];
         rr_data_ff <= mem[req_src_reg];
      end
      if (s1_adv && ex_res.written) begin
         mem[s1_dest_ff] <= ex_res.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         sreg_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            pc_ff   <= ex_res.pc;
            sreg_ff <= ex_res.sreg;
            if (ex_res.written) begin
               valid_ff[s1_dest_ff] <= 1'b1;
            end
         end
         if (req_acc) begin
            fwd_valid_ff <= s1_adv && ex_res.written;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_type_ff  <= req_type;
         s1_dest_ff  <= req_dest_reg;
         s1_src_ff   <= req_src_reg;
         s1_imm_ff   <= req_immediate;
         s1_bit_ff   <= req_bit_sel;
         s1_off_ff   <= req_branch_offset;
         s1_tgt_ff   <= req_jump_target;
         rd_vld_ff   <= valid_ff[req_dest_reg];
         rr_vld_ff   <= valid_ff[req_src_reg];
         fwd_addr_ff <= s1_dest_ff;
         fwd_data_ff <= ex_res.value;
      end
      if (s1_adv) begin
         rsp_ff <= ex_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = PC_PORT_WIDTH'(rsp_ff.pc);
   assign rsp_dest_value   = rsp_ff.written ? rsp_ff.value : 8'h00;
   assign rsp_dest_written = rsp_ff.written;
   assign rsp_status_flags = rsp_ff.sreg;
   assign rsp_branch_taken = rsp_ff.taken;

`ifndef SYNTH
   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> !req_acc)
      else $error("transaction accepted while execute stage is blocked");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("executed transaction produced no result");

   a_state_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (pc_ff == '0 && sreg_ff == 8'h00 && valid_ff == '0))
      else $error("architectural state not cleared by reset");

   a_arch_state_moves_with_exec: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> ($stable(pc_ff) && $stable(sreg_ff)))
      else $error("pc or status changed without an executed transaction");
`endif

endmodule

FILE: rtl/avr_abe_alu.sv
// ----------------------------------------------------------------------------
// avr_abe_alu
// Combinational execute unit: ALU result, status update and next pc.
// ----------------------------------------------------------------------------
module avr_abe_alu (
   input  logic [4:0]                      op,
   input  logic [7:0]                      rd,
   input  logic [7:0]                      rr,
   input  logic [7:0]                      imm,
   input  logic [2:0]                      bit_sel,
   input  logic signed [6:0]               offset,
   input  logic [21:0]                     target,
   input  logic [7:0]                      sreg,
   input  logic [avr_abe_pkg::PC_WIDTH-1:0] pc,
   output avr_abe_pkg::exec_result_type    result
);
   import avr_abe_pkg::*;

   // n, z, v and s = n ^ v
   function automatic logic [7:0] nzvs(input logic [7:0] sr, input logic [7:0] r,
                                       input logic v);
      logic [7:0] o;
      o = sr;
      o[FLAG_N] = r[7];
      o[FLAG_Z] = (r == 8'h00);
      o[FLAG_V] = v;
      o[FLAG_S] = r[7] ^ v;
      return o;
   endfunction

   logic [7:0]          bitm;
   logic                cin;
   logic                sub_cin;
   logic [7:0]          sub_b;
   logic [8:0]          sum9;
   logic [4:0]          sum5;
   logic [8:0]          dif9;
   logic [4:0]          dif5;
   logic [7:0]          res;
   logic [7:0]          sr;
   logic                wr;
   logic                taken;
   logic [PC_WIDTH-1:0] npc;
   logic [PC_WIDTH-1:0] seq_pc;
   logic [PC_WIDTH-1:0] br_pc;

   assign bitm    = 8'b00000001 << bit_sel;
   assign cin     = sreg[FLAG_C];
   assign sum9    = {1'b0, rd} + {1'b0, rr} + {8'h00, cin & (op == OP_ADC)};
   assign sum5    = {1'b0, rd[3:0]} + {1'b0, rr[3:0]} + {4'h0, cin & (op == OP_ADC)};
   assign sub_b   = (op == OP_CPI) ? imm : rr;
   assign sub_cin = cin & (op == OP_CPC);
   assign dif9    = {1'b0, rd} - {1'b0, sub_b} - {8'h00, sub_cin};
   assign dif5    = {1'b0, rd[3:0]} - {1'b0, sub_b[3:0]} - {4'h0, sub_cin};
   assign seq_pc  = pc + PC_WIDTH'(1);
   assign br_pc   = pc + {{(PC_WIDTH-7){offset[6]}}, offset} + PC_WIDTH'(1);

   always_comb begin
      res   = 8'h00;
      sr    = sreg;
      wr    = 1'b0;
      taken = 1'b0;
      npc   = seq_pc;
      case (op)
         OP_ADC, OP_ADD: begin
            res = sum9[7:0];
            sr[FLAG_C] = sum9[8];
            sr[FLAG_H] = sum5[4];
            sr = nzvs(sr, res, ~(rd[7] ^ rr[7]) & (rd[7] ^ res[7]));
            wr = 1'b1;
         end
         OP_AND: begin
            res = rd & rr;
            sr  = nzvs(sr, res, 1'b0);
            wr  = 1'b1;
         end
         OP_ANDI: begin
            res = rd & imm;
            sr  = nzvs(sr, res, 1'b0);
            wr  = 1'b1;
         end
         OP_BCLR: sr = sreg & ~bitm;
         OP_BSET: sr = sreg | bitm;
         OP_BLD: begin
            res = sreg[FLAG_T] ? (rd | bitm) : (rd & ~bitm);
            wr  = 1'b1;
         end
         OP_BST: sr[FLAG_T] = |(rd & bitm);
         OP_BRBC, OP_BRBS: begin
            if ((|(sreg & bitm)) == (op == OP_BRBS)) begin
               npc   = br_pc;
               taken = 1'b1;
            end
         end
         OP_JMP: begin
            npc   = target[PC_WIDTH-1:0];
            taken = 1'b1;
         end
         OP_CBI: begin
            res = rd & ~bitm;
            wr  = 1'b1;
         end
         OP_CBR: begin
            res = rd & ~imm;
            sr  = nzvs(sr, res, 1'b0);
            wr  = 1'b1;
         end
         OP_CLR: begin
            res = 8'h00;
            sr  = nzvs(sr, 8'h00, 1'b0);
            wr  = 1'b1;
         end
         OP_COM: begin
            res = ~rd;
            sr  = nzvs(sr, res, 1'b0);
            sr[FLAG_C] = 1'b1;
            wr  = 1'b1;
         end
         OP_CP, OP_CPC, OP_CPI: begin
            sr[FLAG_C] = dif9[8];
            sr[FLAG_H] = dif5[4];
            sr = nzvs(sr, dif9[7:0], (rd[7] ^ sub_b[7]) & (rd[7] ^ dif9[7]));
            // cpc only ever clears z
            if (op == OP_CPC && dif9[7:0] == 8'h00) begin
               sr[FLAG_Z] = sreg[FLAG_Z];
            end
         end
         OP_DEC: begin
            res = rd - 8'd1;
            sr  = nzvs(sr, res, res == 8'h7F);
            wr  = 1'b1;
         end
         OP_EOR: begin
            res = rd ^ rr;
            sr  = nzvs(sr, res, 1'b0);
            wr  = 1'b1;
         end
         OP_INC: begin
            res = rd + 8'd1;
            sr  = nzvs(sr, res, res == 8'h80);
            wr  = 1'b1;
         end
         OP_LDI: begin
            res = imm;
            wr  = 1'b1;
         end
         OP_LSL: begin
            res = {rd[6:0], 1'b0};
            sr[FLAG_C] = rd[7];
            sr[FLAG_H] = rd[3];
            sr = nzvs(sr, res, rd[6] ^ rd[7]);
            wr = 1'b1;
         end
         OP_LSR: begin
            res = {1'b0, rd[7:1]};
            sr[FLAG_C] = rd[0];
            sr = nzvs(sr, res, rd[0]);
            wr = 1'b1;
         end
         OP_MOV: begin
            res = rr;
            wr  = 1'b1;
         end
         OP_NEG: begin
            res = 8'h00 - rd;
            sr[FLAG_C] = (res != 8'h00);
            sr[FLAG_H] = res[3] | rd[3];
            sr = nzvs(sr, res, res == 8'h80);
            wr = 1'b1;
         end
         OP_SBR: begin
            res = rd | imm;
            sr  = nzvs(sr, res, 1'b0);
            wr  = 1'b1;
         end
         OP_SER: begin
            res = 8'd255;
            wr  = 1'b1;
         end
         OP_TST: sr = nzvs(sr, rd, 1'b0);
         default: ;
      endcase
   end

   assign result.pc      = npc;
   assign result.value   = res;
   assign result.written = wr;
   assign result.sreg    = sr;
   assign result.taken   = taken;

endmodule
